### rtl/sfes_pkg.sv
// Shared types and constants for the spanning forest edge select block.
`default_nettype none

package sfes_pkg;

    // Number of antenna label cells in the chain.
    localparam int MAX_ANTENNAS = 128;
    localparam int ANT_W        = $clog2(MAX_ANTENNAS);
    localparam int LABEL_W      = 7;
    localparam int COUNT_W      = 7;
    localparam int CFG_W        = 8;
    localparam int ID_W         = 16;

    // Largest value of the accepted count, where it saturates.
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // One input item.
    typedef struct packed {
        logic             first_of_set;
        logic [ANT_W-1:0] first_antenna;
        logic [ANT_W-1:0] second_antenna;
        logic [ID_W-1:0]  edge_id;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [ID_W-1:0]    edge_id_out;
        logic               accepted;
        logic [COUNT_W-1:0] accepted_total;
        logic               set_complete;
    } out_item_t;

    // Packet that travels down the row of label cells.
    // A lookup packet gathers the labels of both ends (and may clear labels);
    // an update packet writes new labels and merges groups.
    typedef struct packed {
        logic               vld;
        logic               upd;
        logic               clr;
        logic [ANT_W-1:0]   a1;
        logic [ANT_W-1:0]   a2;
        logic               v1;
        logic [LABEL_W-1:0] l1;
        logic               v2;
        logic [LABEL_W-1:0] l2;
        logic               set1;
        logic               set2;
        logic [LABEL_W-1:0] set_label;
        logic               merge;
        logic [LABEL_W-1:0] keep;
        logic [LABEL_W-1:0] gone;
    } pkt_t;

endpackage

`default_nettype wire

### rtl/sfes_cell.sv
// One antenna label cell: holds one group label and passes packets on.
`default_nettype none

module sfes_cell
    import sfes_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [ANT_W-1:0] cell_index,
    input  wire pkt_t             pkt_in,
    output pkt_t                  pkt_out
);

    logic               valid_reg;
    logic               valid_next;
    logic [LABEL_W-1:0] label_reg;
    logic [LABEL_W-1:0] label_next;
    pkt_t               pkt_reg;
    pkt_t               pkt_next;
    logic               hit1;
    logic               hit2;

    assign hit1 = (pkt_in.a1 == cell_index);
    assign hit2 = (pkt_in.a2 == cell_index);

    // Apply the passing packet to this cell and fill in its lookup answers.
    always_comb
    begin
        valid_next = valid_reg;
        label_next = label_reg;
        pkt_next   = pkt_in;
        if (pkt_in.vld) begin
            if (!pkt_in.upd) begin
                if (pkt_in.clr) begin
                    valid_next = 1'b0;
                end
                if (hit1) begin
                    pkt_next.v1 = valid_reg && !pkt_in.clr;
                    pkt_next.l1 = label_reg;
                end
                if (hit2) begin
                    pkt_next.v2 = valid_reg && !pkt_in.clr;
                    pkt_next.l2 = label_reg;
                end
            end else begin
                if (pkt_in.merge && valid_reg && (label_reg == pkt_in.gone)) begin
                    label_next = pkt_in.keep;
                end
                if ((pkt_in.set1 && hit1) || (pkt_in.set2 && hit2)) begin
                    valid_next = 1'b1;
                    label_next = pkt_in.set_label;
                end
            end
        end
    end

    // Valid bit and the packet stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            pkt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pkt_reg   <= pkt_next;
        end
    end

    // Label storage needs no reset; it is masked by the valid bit.
    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
    end

    assign pkt_out = pkt_reg;

endmodule

`default_nettype wire

### rtl/spanning_forest_edge_select_core.sv
// Top level: edge sequencer in front of a row of antenna label cells.
// A lookup packet is registered in every cell of the row; when it leaves the last cell the decision
// is taken and stored in a pending register, then moved to the output register once that is free.
// A new item is taken only after the previous result has moved into the output register; the
// update packet enters the row at the decision and runs ahead of the next lookup.
// Reset: all labels invalid, count and complete flag zero, antenna_count 128.
`default_nettype none

module spanning_forest_edge_select_core
    import sfes_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire in_item_t         in_data,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output out_item_t             out_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_RES
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   ant_count_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               complete_reg;
    logic [LABEL_W-1:0] next_group_reg;
    logic [ID_W-1:0]    id_reg;
    out_item_t          pend_reg;
    logic               out_valid_reg;
    out_item_t          out_reg;

    pkt_t               chain [0:MAX_ANTENNAS];
    pkt_t               lk;
    logic [CFG_W-1:0]   target;
    logic               in_xfer;
    logic               out_free;
    logic [COUNT_W-1:0] count_eff;
    logic               complete_eff;

    // Decision taken when the lookup packet leaves the row.
    logic               acc;
    logic               new_group;
    logic [COUNT_W-1:0] count_new;
    logic               complete_new;
    pkt_t               upd_pkt;
    pkt_t               inject;

    assign target    = (ant_count_reg >= CFG_W'(2)) ? ant_count_reg - CFG_W'(1) : '0;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign lk        = chain[MAX_ANTENNAS];

    // Count and complete flag as seen by a new item, after an optional clear.
    assign count_eff    = in_data.first_of_set ? '0 : count_reg;
    assign complete_eff = (in_data.first_of_set ? 1'b0 : complete_reg)
                          || ({1'b0, count_eff} >= target);

    // Kruskal step from the two looked-up labels.
    always_comb
    begin
        upd_pkt     = '0;
        upd_pkt.vld = 1'b1;
        upd_pkt.upd = 1'b1;
        upd_pkt.a1  = lk.a1;
        upd_pkt.a2  = lk.a2;
        acc         = 1'b0;
        new_group   = 1'b0;
        if (!complete_reg)
        begin
            if (!lk.v1 && !lk.v2)
            begin
                upd_pkt.set1      = 1'b1;
                upd_pkt.set2      = 1'b1;
                upd_pkt.set_label = next_group_reg;
                new_group         = 1'b1;
                acc               = 1'b1;
            end
            else if (!lk.v1)
            begin
                upd_pkt.set1      = 1'b1;
                upd_pkt.set_label = lk.l2;
                acc               = 1'b1;
            end
            else if (!lk.v2)
            begin
                upd_pkt.set2      = 1'b1;
                upd_pkt.set_label = lk.l1;
                acc               = 1'b1;
            end
            else if (lk.l1 != lk.l2)
            begin
                upd_pkt.merge = 1'b1;
                upd_pkt.keep  = lk.l1;
                upd_pkt.gone  = lk.l2;
                acc           = 1'b1;
            end
        end
        count_new    = count_reg;
        complete_new = complete_reg;
        if (acc)
        begin
            if (count_reg != COUNT_MAX)
            begin
                count_new = count_reg + COUNT_W'(1);
            end
            complete_new = complete_reg || ({1'b0, count_new} >= target);
        end
    end

    // Packet entering the first cell: a lookup on transfer, an update at decision.
    always_comb
    begin
        inject = '0;
        if (in_xfer)
        begin
            inject.vld = 1'b1;
            inject.clr = in_data.first_of_set;
            inject.a1  = in_data.first_antenna;
            inject.a2  = in_data.second_antenna;
        end
        else if ((state_reg == S_LOOK) && lk.vld && !lk.upd)
        begin
            inject = upd_pkt;
        end
    end

    assign chain[0] = inject;

    // Row of label cells.
    for (genvar i = 0; i < MAX_ANTENNAS; i++)
    begin : g_cell
        sfes_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (ANT_W'(i)),
            .pkt_in     (chain[i]),
            .pkt_out    (chain[i+1])
        );
    end

    // Sequencer, configuration and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ant_count_reg  <= CFG_W'(MAX_ANTENNAS);
            count_reg      <= '0;
            complete_reg   <= 1'b0;
            next_group_reg <= '0;
            id_reg         <= '0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ant_count_reg <= cfg_data;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        id_reg       <= in_data.edge_id;
                        count_reg    <= count_eff;
                        complete_reg <= complete_eff;
                        if (in_data.first_of_set)
                        begin
                            next_group_reg <= '0;
                        end
                        state_reg <= S_LOOK;
                    end
                end
                S_LOOK:
                begin
                    if (lk.vld && !lk.upd)
                    begin
                        count_reg    <= count_new;
                        complete_reg <= complete_new;
                        if (new_group)
                        begin
                            next_group_reg <= next_group_reg + LABEL_W'(1);
                        end
                        pend_reg.edge_id_out    <= id_reg;
                        pend_reg.accepted       <= acc;
                        pend_reg.accepted_total <= count_new;
                        pend_reg.set_complete   <= complete_new;
                        state_reg               <= S_RES;
                    end
                end
                S_RES:
                begin
                    if (out_free)
                    begin
                        out_reg       <= pend_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

### bench/sfes_forest_checker.sv
// Checker for the spanning forest edge select core: predicts each result and compares it.
module sfes_forest_checker
    import sfes_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_stall,
    input  wire in_item_t         in_data,
    input  wire logic             out_valid,
    input  wire logic             out_stall,
    input  wire out_item_t        out_data,
    input  wire logic             cfg_valid,
    input  wire logic             cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,
    output int                    failures,
    output int                    pending
);

    // Shadow copy of the forest: one group label per antenna plus its valid bit.
    logic [LABEL_W-1:0] label_of [MAX_ANTENNAS];
    bit                 labelled [MAX_ANTENNAS];
    logic [COUNT_W-1:0] edges_taken;
    bit                 forest_done;
    logic [LABEL_W-1:0] fresh_group;
    logic [CFG_W-1:0]   antenna_cfg;

    // Verdicts predicted for transferred edges, oldest first.
    out_item_t expected_verdicts [$];

    // Drop every label and start a new set.
    function void clear_forest();
        int i;
        for (i = 0; i < MAX_ANTENNAS; i++)
        begin
            label_of[i] = '0;
            labelled[i] = 0;
        end
        edges_taken = '0;
        forest_done = 0;
        fresh_group = '0;
    endfunction

    // Decide one edge against the shadow forest and update it.
    function automatic out_item_t judge_edge(input in_item_t e);
        out_item_t          r;
        int                 target;
        int                 i;
        bit                 take;
        logic [ANT_W-1:0]   a;
        logic [ANT_W-1:0]   b;
        logic [LABEL_W-1:0] keep;
        logic [LABEL_W-1:0] gone;
        a      = e.first_antenna;
        b      = e.second_antenna;
        target = (antenna_cfg >= 2) ? int'(antenna_cfg) - 1 : 0;
        take   = 0;
        if (e.first_of_set)
            clear_forest();
        if (int'(edges_taken) >= target)
            forest_done = 1;
        if (!forest_done)
        begin
            if (!labelled[a] && !labelled[b])
            begin
                // Both ends new: they open a fresh group together.
                label_of[a] = fresh_group;
                label_of[b] = fresh_group;
                labelled[a] = 1;
                labelled[b] = 1;
                fresh_group = fresh_group + 1'b1;
                take        = 1;
            end
            else if (!labelled[a])
            begin
                label_of[a] = label_of[b];
                labelled[a] = 1;
                take        = 1;
            end
            else if (!labelled[b])
            begin
                label_of[b] = label_of[a];
                labelled[b] = 1;
                take        = 1;
            end
            else if (label_of[a] != label_of[b])
            begin
                // Two groups meet: the second end's group joins the first.
                keep = label_of[a];
                gone = label_of[b];
                for (i = 0; i < MAX_ANTENNAS; i++)
                    if (labelled[i] && label_of[i] == gone)
                        label_of[i] = keep;
                take = 1;
            end
            if (take)
            begin
                if (edges_taken != COUNT_MAX)
                    edges_taken = edges_taken + 1'b1;
                if (int'(edges_taken) >= target)
                    forest_done = 1;
            end
        end
        r.edge_id_out    = e.edge_id;
        r.accepted       = take;
        r.accepted_total = edges_taken;
        r.set_complete   = forest_done;
        return r;
    endfunction

    // Compare one result field and count a mismatch.
    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
        end
    endfunction

    // Follow register writes, predict each input transfer, check each output transfer.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            failures    = 0;
            antenna_cfg = CFG_W'(MAX_ANTENNAS);
            clear_forest();
            expected_verdicts.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                antenna_cfg = cfg_data;
            if (in_valid && !in_stall)
                expected_verdicts.insert(expected_verdicts.size(), judge_edge(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("unexpected result transfer, edge_id_out %0d", out_data.edge_id_out);
                    failures++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("edge_id_out", want.edge_id_out, out_data.edge_id_out);
                    check_field("accepted", 16'(want.accepted), 16'(out_data.accepted));
                    check_field("accepted_total", 16'(want.accepted_total),
                                16'(out_data.accepted_total));
                    check_field("set_complete", 16'(want.set_complete),
                                16'(out_data.set_complete));
                end
            end
        end
        pending = expected_verdicts.size();
    end

endmodule

### bench/tb_spanning_forest_edge_select_core.sv
// Testbench top for the spanning forest edge select core: stimulus, clock, reset and verdict.
module tb_spanning_forest_edge_select_core;
    import sfes_pkg::*;

    localparam int ITEMS       = 1800;
    localparam int CYCLE_LIMIT = 1500000;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    in_item_t         in_data;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    int failures;
    int pending;
    int cycles = 0;
    int sent_count = 0;

    spanning_forest_edge_select_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sfes_forest_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter with a hard stop on a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_spanning_forest_edge_select_core: FAIL");
            $finish;
        end
    end

    // Random output back-pressure, with a quiet stretch where it never stalls.
    always @(negedge clk)
    begin
        if (cycles > 40000 && cycles < 90000)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 11);
    end

    // Offer one edge and hold it until the transfer happens; starts and ends at a falling edge.
    task automatic send_edge(input in_item_t item);
        bool_gap: if ((sent_count < 300 || sent_count > 700) && $urandom_range(0, 99) < 11)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 150)) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        do @(posedge clk); while (in_stall);
        sent_count++;
        @(negedge clk);
    endtask

    // Directed edge with fixed ends and identifier.
    task automatic directed_edge(input bit first, input int a, input int b, input int id);
        in_item_t e;
        e.first_of_set   = first;
        e.first_antenna  = ANT_W'(a);
        e.second_antenna = ANT_W'(b);
        e.edge_id        = ID_W'(id);
        send_edge(e);
    endtask

    // Set the antenna count once every predicted result has come back.
    task automatic write_antenna_count(input int value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Random edge, mostly among the first span antennas, sometimes a self edge.
    function automatic in_item_t random_edge(input bit first, input int span, input int self_pct);
        in_item_t e;
        e.first_of_set   = first;
        e.first_antenna  = ANT_W'(($urandom_range(0, 99) < 90) ? $urandom_range(0, span - 1)
                                                               : $urandom_range(0, 127));
        e.second_antenna = ANT_W'(($urandom_range(0, 99) < 90) ? $urandom_range(0, span - 1)
                                                               : $urandom_range(0, 127));
        if ($urandom_range(0, 99) < self_pct)
            e.second_antenna = e.first_antenna;
        e.edge_id = ID_W'($urandom_range(0, 65535));
        return e;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int pick;
        int count;
        int span;
        int len;
        int k;
        bit first;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Default count: self edge, repeat, new pair, one-sided joins, merges, a rejection.
        directed_edge(1, 0, 0, 0);
        directed_edge(0, 0, 0, 1);
        directed_edge(0, 1, 2, 2);
        directed_edge(0, 3, 1, 3);
        directed_edge(0, 2, 5, 4);
        directed_edge(0, 0, 3, 5);
        directed_edge(0, 127, 126, 6);
        directed_edge(0, 5, 127, 7);
        directed_edge(0, 126, 0, 16'hFFFF);

        // Small set that completes, then edges past completion.
        write_antenna_count(4);
        directed_edge(1, 10, 11, 8);
        directed_edge(0, 12, 13, 9);
        directed_edge(0, 11, 13, 10);
        directed_edge(0, 20, 21, 11);

        // Raising the count mid-set leaves a complete set complete.
        write_antenna_count(6);
        directed_edge(0, 30, 31, 12);
        directed_edge(1, 30, 31, 13);

        // Counts below two: complete from the start.
        write_antenna_count(0);
        directed_edge(0, 40, 41, 14);
        directed_edge(1, 40, 41, 15);
        write_antenna_count(1);
        directed_edge(1, 42, 43, 16);

        // Smallest useful count: one self edge completes the set.
        write_antenna_count(2);
        directed_edge(1, 44, 44, 17);
        directed_edge(0, 45, 46, 18);

        // Long sets over all antennas; self edges push the count into saturation.
        write_antenna_count(255);
        for (k = 0; k < 400; k++)
            send_edge(random_edge(k == 0, 128, 25));
        write_antenna_count(128);
        for (k = 0; k < 300; k++)
            send_edge(random_edge(k == 0, 128, 10));

        // Random phases of mostly small antenna counts with well-formed sets.
        while (sent_count < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                count = $urandom_range(2, 16);
            else if (pick < 85)
                count = $urandom_range(17, 60);
            else if (pick < 93)
                count = $urandom_range(0, 255);
            else
                count = $urandom_range(0, 1);
            write_antenna_count(count);
            span = (count < 2) ? 2 : ((count > 128) ? 128 : count);
            repeat ($urandom_range(1, 4))
            begin
                len = $urandom_range(1, 2 * span + 4);
                if (len > 150)
                    len = 150;
                for (k = 0; k < len; k++)
                begin
                    // A set normally opens with a clear; a few sets continue the old one.
                    first = (k == 0) ? ($urandom_range(0, 99) < 90)
                                     : ($urandom_range(0, 99) < 3);
                    send_edge(random_edge(first, span, 5));
                end
            end
        end
        in_valid = 1'b0;

        // Drain, then give the block time to show any extra result.
        while (pending != 0) @(negedge clk);
        repeat (MAX_ANTENNAS + 8) @(negedge clk);
        if (failures == 0 && pending == 0)
            $display("tb_spanning_forest_edge_select_core: PASS");
        else
            $display("tb_spanning_forest_edge_select_core: FAIL");
        $finish;
    end

endmodule
